FILE: hw/rtl/smsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smsa_pkg;

  localparam int DIM_DEF = 9;
  localparam int OP_W    = 4;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ANS_W   = 36;
  localparam int STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 4'd0,
    OP_REMOVE   = 4'd1,
    OP_READ     = 4'd2,
    OP_ROW_CNT  = 4'd3,
    OP_ROW_SUM  = 4'd4,
    OP_COL_CNT  = 4'd5,
    OP_COL_SUM  = 4'd6,
    OP_MAIN_SUM = 4'd7,
    OP_ANTI_SUM = 4'd8
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_MISSING  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Commands from the sequencer to the cell store.
  typedef struct packed {
    logic rd;
    logic set;
    logic clr;
  } mem_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smsa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smsa_req_if
  import smsa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] cell_data;

  modport source (output valid, operation, row_index, col_index, cell_data, input ready);
  modport sink (input valid, operation, row_index, col_index, cell_data, output ready);
endinterface

interface smsa_rsp_if
  import smsa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [ANS_W-1:0] answer;

  modport source (output valid, status, answer, input ready);
  modport sink (input valid, status, answer, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sparse_matrix_store_with_aggregates_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sparse DIM x DIM matrix store with row, column and diagonal aggregates.
// Items arrive on the req channel (operation, one-based row and column,
// data for insert); each produces exactly one result (status, answer) on
// the rsp channel. A transfer happens when valid and ready are both high.
// Cell values live in a single-port synchronous memory; occupied bits are
// flip-flops that reset clears, so no clearing pass is needed.
// One item is worked on at a time: it is taken in S_IDLE, reads the store in
// S_SCAN (insert and remove then write it in S_DRAIN) and loads the output
// register from S_DONE, then the sequencer is idle again. Insert, remove and
// read make one memory access; row, column and diagonal aggregates read one
// cell per cycle from the memory port. Index errors and unknown codes skip it.
// An output register holds a finished result, so req may accept the next
// item while rsp is stalled; when both the register and the sequencer hold a
// result, req waits until rsp takes the oldest one.
// Synchronous reset returns the sequencer to idle, empties the output
// register and marks every cell empty.

module sparse_matrix_store_with_aggregates_top
  import smsa_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  smsa_req_if.sink   req,
  smsa_rsp_if.source rsp
);

  localparam int AW = $clog2(DIM * DIM);

  mem_cmd_t          cmd;
  logic [AW-1:0]     addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;
  logic              rd_occ;

  smsa_ctrl #(
    .DIM(DIM)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cmd     (cmd),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_occ  (rd_occ)
  );

  smsa_store #(
    .DIM(DIM)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .addr    (addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_occ  (rd_occ)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/smsa_store.sv
`timescale 1ns / 1ps
`default_nettype none

module smsa_store
  import smsa_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mem_cmd_t                   cmd,
  input  wire logic [$clog2(DIM*DIM)-1:0] addr,
  input  wire logic [DATA_W-1:0]          wr_data,
  output logic      [DATA_W-1:0]          rd_data,
  output logic                            rd_occ
);

  localparam int DEPTH = DIM * DIM;

  logic [DATA_W-1:0] vals [DEPTH];
  logic [DEPTH-1:0]  occ;

  // Values have no reset; only cells with their occupied bit set are used.
  always_ff @(posedge clk) begin
    if (cmd.set) begin
      vals[addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= vals[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.set) begin
      occ[addr] <= 1'b1;
    end else if (cmd.clr) begin
      occ[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_occ <= occ[addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smsa_ctrl
  import smsa_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  smsa_req_if.sink                        req,
  smsa_rsp_if.source                      rsp,
  output mem_cmd_t                        cmd,
  output logic [$clog2(DIM*DIM)-1:0]      addr,
  output logic [DATA_W-1:0]               wr_data,
  input  wire logic [DATA_W-1:0]          rd_data,
  input  wire logic                       rd_occ
);

  localparam int IW = $clog2(DIM);
  localparam int AW = $clog2(DIM * DIM);

  state_t state, state_next;

  op_t                     op;
  logic [IW-1:0]           r0;
  logic [IW-1:0]           c0;
  logic [IW-1:0]           cnt;
  logic                    rd_vld;
  logic signed [ANS_W-1:0] acc;
  stat_t                   status;
  logic                    out_valid;
  stat_t                   out_status;
  logic signed [ANS_W-1:0] out_answer;

  logic                    accept;
  logic                    row_ok;
  logic                    col_ok;
  logic                    go_scan;
  logic                    bad_index;
  logic                    last;
  logic                    load_out;
  logic signed [ANS_W-1:0] term;
  logic [IW-1:0]           ar;
  logic [IW-1:0]           ac;

  assign row_ok = (req.row_index != '0) && ({1'b0, req.row_index} <= (IDX_W + 1)'(DIM));
  assign col_ok = (req.col_index != '0) && ({1'b0, req.col_index} <= (IDX_W + 1)'(DIM));
  assign accept = req.valid && req.ready;

  // Decide at acceptance whether the item needs the store at all.
  always_comb begin
    go_scan   = 1'b0;
    bad_index = 1'b0;
    unique case (req.operation)
      OP_INSERT, OP_REMOVE, OP_READ: begin
        go_scan   = row_ok && col_ok;
        bad_index = !(row_ok && col_ok);
      end
      OP_ROW_CNT, OP_ROW_SUM: begin
        go_scan   = row_ok;
        bad_index = !row_ok;
      end
      OP_COL_CNT, OP_COL_SUM: begin
        go_scan   = col_ok;
        bad_index = !col_ok;
      end
      OP_MAIN_SUM, OP_ANTI_SUM: begin
        go_scan = 1'b1;
      end
      default: begin
        go_scan = 1'b0;
      end
    endcase
  end

  // Cell coordinates of the current step.
  always_comb begin
    unique case (op)
      OP_ROW_CNT, OP_ROW_SUM: begin
        ar = r0;
        ac = cnt;
      end
      OP_COL_CNT, OP_COL_SUM: begin
        ar = cnt;
        ac = c0;
      end
      OP_MAIN_SUM: begin
        ar = cnt;
        ac = cnt;
      end
      OP_ANTI_SUM: begin
        ar = cnt;
        ac = IW'(DIM - 1) - cnt;
      end
      default: begin
        ar = r0;
        ac = c0;
      end
    endcase
  end

  assign addr    = AW'(ar) * AW'(DIM) + AW'(ac);
  assign last    = (op == OP_INSERT) || (op == OP_REMOVE) || (op == OP_READ)
                   || (cnt == IW'(DIM - 1));
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    unique case (op)
      OP_ROW_CNT, OP_COL_CNT: begin
        term = ANS_W'(rd_occ);
      end
      OP_READ, OP_ROW_SUM, OP_COL_SUM, OP_MAIN_SUM, OP_ANTI_SUM: begin
        term = rd_occ ? {{(ANS_W - DATA_W){rd_data[DATA_W-1]}}, rd_data} : '0;
      end
      default: begin
        term = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = go_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.set    = (op == OP_INSERT) && !rd_occ;
        cmd.clr    = (op == OP_REMOVE) && rd_occ;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (accept) begin
        cnt <= '0;
      end else if (state == S_SCAN && !last) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= op_t'(req.operation);
      r0      <= IW'(req.row_index - 1'b1);
      c0      <= IW'(req.col_index - 1'b1);
      wr_data <= req.cell_data;
      acc     <= '0;
      status  <= bad_index ? ST_MISSING : ST_OK;
    end else begin
      if (rd_vld) begin
        acc <= acc + term;
      end
      if (state == S_DRAIN) begin
        if (op == OP_INSERT && rd_occ) begin
          status <= ST_OCCUPIED;
        end else if ((op == OP_REMOVE || op == OP_READ) && !rd_occ) begin
          status <= ST_MISSING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= status;
      out_answer <= (status == ST_OK) ? acc : '0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.answer = out_answer;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.answer == '0)
    else $error("error result with nonzero answer");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer stayed idle after a transfer");

  a_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.set |-> (state == S_DRAIN) && (op == OP_INSERT) && !cmd.clr)
    else $error("store written outside insert");

  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> rd_vld && $past(state) == S_SCAN)
    else $error("drain without pending read");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt <= IW'(DIM - 1))
    else $error("scan step out of range");

endmodule

`default_nettype wire

FILE: bench/sparse_matrix_store_with_aggregates_top_tb.sv
`timescale 1ns / 1ps

module sparse_matrix_store_with_aggregates_top_tb;
  import smsa_pkg::*;

  localparam int DIM = DIM_DEF;
  localparam int CELLS = DIM * DIM;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] data;
  } matrix_request_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [ANS_W-1:0] answer;
  } matrix_result_t;

  // Shadow copy of the matrix; it turns every accepted request into the result it must produce.
  class matrix_shadow;
    logic signed [DATA_W-1:0] cell_value[CELLS];
    bit                       cell_taken[CELLS];
    matrix_result_t           pending_results[$];
    int                       errors;

    function new();
      foreach (cell_taken[k]) cell_taken[k] = 0;
      foreach (cell_value[k]) cell_value[k] = '0;
      errors = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic signed [DATA_W-1:0] data);
      bit                      row_ok;
      bit                      col_ok;
      int                      k;
      logic [STAT_W-1:0]       st;
      logic signed [ANS_W-1:0] acc;
      matrix_result_t          res;
      row_ok = (row >= 1) && (row <= DIM);
      col_ok = (col >= 1) && (col <= DIM);
      st = ST_OK;
      acc = '0;
      case (op)
        OP_INSERT, OP_REMOVE, OP_READ: begin
          if (!row_ok || !col_ok) begin
            st = ST_MISSING;
          end else begin
            k = (int'(row) - 1) * DIM + (int'(col) - 1);
            if (op == OP_INSERT) begin
              if (cell_taken[k]) begin
                st = ST_OCCUPIED;
              end else begin
                cell_value[k] = data;
                cell_taken[k] = 1;
              end
            end else if (!cell_taken[k]) begin
              st = ST_MISSING;
            end else if (op == OP_REMOVE) begin
              cell_taken[k] = 0;
            end else begin
              acc = cell_value[k];
            end
          end
        end
        OP_ROW_CNT, OP_ROW_SUM: begin
          if (!row_ok) begin
            st = ST_MISSING;
          end else begin
            for (int i = 0; i < DIM; i++) begin
              k = (int'(row) - 1) * DIM + i;
              if (cell_taken[k]) acc = (op == OP_ROW_CNT) ? acc + 1 : acc + cell_value[k];
            end
          end
        end
        OP_COL_CNT, OP_COL_SUM: begin
          if (!col_ok) begin
            st = ST_MISSING;
          end else begin
            for (int i = 0; i < DIM; i++) begin
              k = i * DIM + (int'(col) - 1);
              if (cell_taken[k]) acc = (op == OP_COL_CNT) ? acc + 1 : acc + cell_value[k];
            end
          end
        end
        OP_MAIN_SUM: begin
          for (int i = 0; i < DIM; i++) begin
            k = i * DIM + i;
            if (cell_taken[k]) acc = acc + cell_value[k];
          end
        end
        OP_ANTI_SUM: begin
          for (int i = 0; i < DIM; i++) begin
            k = i * DIM + (DIM - 1 - i);
            if (cell_taken[k]) acc = acc + cell_value[k];
          end
        end
        default: ;
      endcase
      if (st != ST_OK) acc = '0;
      res.status = st;
      res.answer = acc;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic signed [ANS_W-1:0] answer);
      matrix_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, answer %0d", status, answer);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
      if (answer !== exp_res.answer) begin
        $error("answer: expected %0d, got %0d", exp_res.answer, answer);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  smsa_req_if req_bus ();
  smsa_rsp_if rsp_bus ();

  sparse_matrix_store_with_aggregates_top #(
    .DIM(DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  matrix_shadow sb;
  int burst_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Both channels are observed at the rising edge, where every transfer happens.
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready)
      sb.note_request(req_bus.operation, req_bus.row_index, req_bus.col_index,
                      req_bus.cell_data);
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      sb.check_result(rsp_bus.status, rsp_bus.answer);
  end

  // The receiver switches among steady, random, sparse and long-stall behaviors.
  int stall_mode;
  int mode_left;
  int stall_count;
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      mode_left <= 0;
      stall_count <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3);
        mode_left <= $urandom_range(80, 10);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_count <= stall_count + 1;
      case (stall_mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= $urandom_range(1);
        2: rsp_bus.ready <= (stall_count % 4) == 0;
        default: rsp_bus.ready <= (stall_count % 12) >= 9;
      endcase
    end
  end

  // Called at a falling edge; returns at a falling edge after the transfer, at times after a gap with valid low.
  task automatic send_request(matrix_request_t item);
    req_bus.valid     <= 1'b1;
    req_bus.operation <= item.op;
    req_bus.row_index <= item.row;
    req_bus.col_index <= item.col;
    req_bus.cell_data <= item.data;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      if ($urandom_range(3) != 0) begin
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(($urandom_range(9) == 0) ? 25 : 5, 1)) @(negedge clk);
      end
    end
  endtask

  task automatic send_fields(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [DATA_W-1:0] data);
    matrix_request_t item;
    item.op = op;
    item.row = row;
    item.col = col;
    item.data = data;
    send_request(item);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count);
    matrix_request_t item;
    int roll;
    bit filling;
    for (int n = 0; n < count; n++) begin
      filling = ((n / 150) % 2) == 0;
      roll = $urandom_range(99);
      item.data = pick_data();
      item.row = $urandom_range(DIM, 1);
      item.col = $urandom_range(DIM, 1);
      if (roll < 8) begin
        // Noise: any code, any index, including out-of-range ones.
        item.op = $urandom_range(15);
        item.row = $urandom_range(15);
        item.col = $urandom_range(15);
      end else begin
        roll = $urandom_range(99);
        if (roll < (filling ? 40 : 10)) begin
          item.op = OP_INSERT;
        end else if (roll < 50) begin
          item.op = OP_REMOVE;
        end else if (roll < 65) begin
          item.op = OP_READ;
        end else begin
          item.op = $urandom_range(OP_ANTI_SUM, OP_ROW_CNT);
          // Indices an aggregate does not use take any value.
          if (item.op == OP_ROW_CNT || item.op == OP_ROW_SUM) item.col = $urandom_range(15);
          if (item.op == OP_COL_CNT || item.op == OP_COL_SUM) item.row = $urandom_range(15);
          if (item.op == OP_MAIN_SUM || item.op == OP_ANTI_SUM) begin
            item.row = $urandom_range(15);
            item.col = $urandom_range(15);
          end
        end
      end
      send_request(item);
    end
  endtask

  initial begin
    sb = new();
    burst_left = 0;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.operation = '0;
    req_bus.row_index = '0;
    req_bus.col_index = '0;
    req_bus.cell_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Corners of the matrix with extreme values, then every operation on them.
    send_fields(OP_INSERT, 1, 1, 32'sh7FFF_FFFF);
    send_fields(OP_INSERT, DIM, DIM, 32'sh8000_0000);
    send_fields(OP_INSERT, 1, DIM, -32'sd1);
    send_fields(OP_INSERT, DIM, 1, 32'sd5);
    send_fields(OP_INSERT, 1, 1, 32'sd7);
    send_fields(OP_READ, 1, 1, 32'sh1234_5678);
    send_fields(OP_READ, DIM, DIM, '0);
    send_fields(OP_READ, 5, 5, '0);
    send_fields(OP_ROW_CNT, 1, 3, '0);
    send_fields(OP_ROW_SUM, DIM, 2, '0);
    send_fields(OP_COL_CNT, 4, 1, '0);
    send_fields(OP_COL_SUM, 2, DIM, '0);
    send_fields(OP_MAIN_SUM, 0, 0, '0);
    send_fields(OP_ANTI_SUM, 15, 15, '0);
    send_fields(OP_REMOVE, 5, 5, '0);
    send_fields(OP_REMOVE, 1, DIM, '0);
    send_fields(OP_ANTI_SUM, 1, 1, '0);
    // Out-of-range indices and unknown codes must change nothing.
    send_fields(OP_READ, 0, 1, '0);
    send_fields(OP_INSERT, 1, 10, 32'sd99);
    send_fields(OP_ROW_SUM, 0, 1, '0);
    send_fields(OP_COL_CNT, 1, 15, '0);
    send_fields(4'd9, 1, 1, '0);
    send_fields(4'd15, 15, 15, 32'shFFFF_FFFF);
    // Unused indices are ignored even when out of range.
    send_fields(OP_ROW_CNT, 1, 0, '0);
    send_fields(OP_COL_SUM, 15, DIM, '0);

    run_random(RANDOM_ITEMS);
    req_bus.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sparse_matrix_store_with_aggregates_top.f
hw/rtl/smsa_pkg.sv
hw/rtl/smsa_if.sv
hw/rtl/smsa_store.sv
hw/rtl/smsa_ctrl.sv
hw/rtl/sparse_matrix_store_with_aggregates_top.sv
bench/sparse_matrix_store_with_aggregates_top_tb.sv
